>>> design/bws_pkg.sv
// Package for the burn-wire pulse sequencer: beat types, register set,
// request, channel and status codes, and reset values.
// No dependencies.
package bws_pkg;

  // Configuration port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int UNITS_W    = 16;
  localparam int ON_MS_W    = 6;
  // Millisecond counter width; every legal period length fits in it
  localparam int MS_W       = 6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ANTENNA_UNITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_UNITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_ON_MS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_ON_MS    = 2'd3;

  // Register reset values
  localparam logic [UNITS_W-1:0] RST_ANTENNA_UNITS = 16'd30;
  localparam logic [UNITS_W-1:0] RST_SPRITE_UNITS  = 16'd30;
  localparam logic [ON_MS_W-1:0] RST_SHORT_ON_MS   = 6'd5;
  localparam logic [ON_MS_W-1:0] RST_LONG_ON_MS    = 6'd15;

  // Request codes
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // Channel codes
  localparam logic [2:0] CH_ANT1 = 3'd0;
  localparam logic [2:0] CH_ANT2 = 3'd1;
  localparam logic [2:0] CH_DEP1 = 3'd2;
  localparam logic [2:0] CH_DEP2 = 3'd3;
  localparam logic [2:0] CH_BOTH = 3'd4;

  // Result status
  typedef enum logic [1:0] {
    ST_TICK   = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef struct packed {
    logic [UNITS_W-1:0] antenna_burn_units;
    logic [UNITS_W-1:0] sprite_burn_units;
    logic [ON_MS_W-1:0] short_on_ms;
    logic [ON_MS_W-1:0] long_on_ms;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [2:0] channel;
  } in_item_t;

  typedef struct packed {
    logic [3:0] heater_pins;
    logic       relay_a_on;
    logic       relay_b_on;
    logic       busy_res;
    logic [3:0] done_flags;
    logic [1:0] status;
  } out_item_t;

endpackage

>>> design/bws_cfg_regs.sv
// Configuration register file for the burn-wire pulse sequencer.
// Depends on bws_pkg.
module bws_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bws_pkg::CFG_DATA_W-1:0] cfg_data,
  output bws_pkg::cfg_t                  cfg
);

  // Load reset values, then take writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.antenna_burn_units <= bws_pkg::RST_ANTENNA_UNITS;
      cfg.sprite_burn_units  <= bws_pkg::RST_SPRITE_UNITS;
      cfg.short_on_ms        <= bws_pkg::RST_SHORT_ON_MS;
      cfg.long_on_ms         <= bws_pkg::RST_LONG_ON_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        bws_pkg::CFG_ANTENNA_UNITS: begin
          cfg.antenna_burn_units <= cfg_data[bws_pkg::UNITS_W-1:0];
        end
        bws_pkg::CFG_SPRITE_UNITS: begin
          cfg.sprite_burn_units <= cfg_data[bws_pkg::UNITS_W-1:0];
        end
        bws_pkg::CFG_SHORT_ON_MS: begin
          cfg.short_on_ms <= cfg_data[bws_pkg::ON_MS_W-1:0];
        end
        bws_pkg::CFG_LONG_ON_MS: begin
          cfg.long_on_ms <= cfg_data[bws_pkg::ON_MS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> design/bws_core.sv
// Burn state and single-pass step logic: takes one staged beat and gives
// the next state and the result beat. Depends on bws_pkg.
module bws_core #(
  parameter int PERIOD_MS        = 50,
  parameter int PERIODS_PER_UNIT = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  bws_pkg::in_item_t   item,
  input  bws_pkg::cfg_t       cfg,
  output bws_pkg::out_item_t  result
);

  // Period counter holds any unit count times periods per unit
  localparam int PD_W = $clog2(((1 << bws_pkg::UNITS_W) - 1) * PERIODS_PER_UNIT + 1);
  localparam logic [bws_pkg::MS_W-1:0] MS_LAST = bws_pkg::MS_W'(PERIOD_MS - 1);
  localparam logic [PD_W-1:0] PPU = PD_W'(PERIODS_PER_UNIT);

  logic                    burning;
  logic [1:0]              active_channel;
  logic                    second_antenna_pending;
  logic [bws_pkg::MS_W-1:0] ms_in_period;
  logic [PD_W-1:0]         periods_done;
  logic [3:0]              completed;

  logic                    burning_next;
  logic [1:0]              active_channel_next;
  logic                    second_antenna_pending_next;
  logic [bws_pkg::MS_W-1:0] ms_in_period_next;
  logic [PD_W-1:0]         periods_done_next;
  logic [3:0]              completed_next;

  logic                    check_end;
  logic [bws_pkg::UNITS_W-1:0] units;
  logic [PD_W-1:0]         total;
  logic [bws_pkg::ON_MS_W-1:0] on_ms;
  bws_pkg::status_t        status;

  // Work out the state after this beat; a burn end may chain into antenna 2
  always_comb begin
    burning_next                = burning;
    active_channel_next         = active_channel;
    second_antenna_pending_next = second_antenna_pending;
    ms_in_period_next           = ms_in_period;
    periods_done_next           = periods_done;
    completed_next              = completed;
    check_end                   = 1'b0;
    status                      = bws_pkg::ST_TICK;
    units                       = '0;
    total                       = '0;

    if (item.req_type == bws_pkg::REQ_TICK) begin
      if (burning) begin
        if (ms_in_period == MS_LAST) begin
          ms_in_period_next = '0;
          periods_done_next = periods_done + 1'b1;
          check_end         = 1'b1;
        end else begin
          ms_in_period_next = ms_in_period + 1'b1;
        end
      end
    end else if (burning || (item.channel > bws_pkg::CH_BOTH)) begin
      status = bws_pkg::ST_REJECT;
    end else begin
      status = bws_pkg::ST_ACCEPT;
      if (item.channel == bws_pkg::CH_BOTH) begin
        second_antenna_pending_next = 1'b1;
        active_channel_next         = bws_pkg::CH_ANT1[1:0];
      end else begin
        second_antenna_pending_next = 1'b0;
        active_channel_next         = item.channel[1:0];
      end
      burning_next      = 1'b1;
      ms_in_period_next = '0;
      periods_done_next = '0;
      check_end         = 1'b1;
    end

    // At most two burns can end in one beat
    for (int i = 0; i < 2; i++) begin
      units = (active_channel_next == bws_pkg::CH_DEP2[1:0]) ?
              cfg.sprite_burn_units : cfg.antenna_burn_units;
      total = PD_W'(PD_W'(units) * PPU);
      if (check_end && burning_next && (periods_done_next >= total)) begin
        burning_next   = 1'b0;
        completed_next = completed_next | (4'b0001 << active_channel_next);
        if (second_antenna_pending_next) begin
          second_antenna_pending_next = 1'b0;
          active_channel_next         = bws_pkg::CH_ANT2[1:0];
          burning_next                = 1'b1;
          ms_in_period_next           = '0;
          periods_done_next           = '0;
        end
      end
    end
  end

  // Drive pins and relays from the next state
  always_comb begin
    on_ms = (active_channel_next == bws_pkg::CH_DEP2[1:0]) ? cfg.long_on_ms : cfg.short_on_ms;
    result.heater_pins = (burning_next && (ms_in_period_next < on_ms)) ?
                         (4'b0001 << active_channel_next) : 4'b0000;
    result.relay_a_on  = burning_next && !active_channel_next[0];
    result.relay_b_on  = burning_next && active_channel_next[0];
    result.busy_res    = burning_next;
    result.done_flags  = completed_next;
    result.status      = status;
  end

  // Advance the state once per staged beat
  always_ff @(posedge clk) begin
    if (rst) begin
      burning                <= 1'b0;
      active_channel         <= '0;
      second_antenna_pending <= 1'b0;
      ms_in_period           <= '0;
      periods_done           <= '0;
      completed              <= '0;
    end else if (step) begin
      burning                <= burning_next;
      active_channel         <= active_channel_next;
      second_antenna_pending <= second_antenna_pending_next;
      ms_in_period           <= ms_in_period_next;
      periods_done           <= periods_done_next;
      completed              <= completed_next;
    end
  end

  // Millisecond counter stays inside one period
  a_ms_range: assert property (@(posedge clk) disable iff (rst)
    ms_in_period <= MS_LAST)
    else $error("ms_in_period left the period");

  // Done bits are sticky
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((completed & $past(completed)) == $past(completed)))
    else $error("completed bit cleared");

  // A pending second antenna only rides on a running antenna 1 burn
  a_pending: assert property (@(posedge clk) disable iff (rst)
    second_antenna_pending |-> (burning && (active_channel == bws_pkg::CH_ANT1[1:0])))
    else $error("second antenna pending without antenna 1 burn");

  // A heater pin is only driven with its relay on
  a_pin_relay: assert property (@(posedge clk) disable iff (rst)
    (result.heater_pins != 4'b0000) |-> (result.relay_a_on != result.relay_b_on))
    else $error("heater pin without exactly one relay");

endmodule

>>> design/burn_wire_pulse_sequencer.sv
// Top level of the burn-wire pulse sequencer: input stage, output stage,
// register file and core. Depends on bws_pkg, bws_cfg_regs, bws_core.
//
// Usage:
//   in_valid/in_ready/in_item carry request beats: a one-millisecond tick
//   or a start command naming antenna 1, antenna 2, deploy 1, deploy 2 or
//   both antennas in turn. out_valid/out_ready/out_item carry one result
//   beat per request: heater pins, relays, busy, sticky done flags, status.
//   cfg_we/cfg_index/cfg_data write one of the four registers, chosen by cfg_index;
//   write them only while no request is in flight.
// Path: an accepted request waits in the input stage, and its result is
//   registered into the output stage once that stage is free.
// Throughput: one request per cycle while out_ready is high; the state update
//   is a single pass of counter, compare and select logic between the two stages.
// Reset: burn idle, counters and done flags clear, registers at their
//   reset values (30 units, 30 units, 5 ms, 15 ms); no beats pending.
// Stall: while out_ready is low the result is held and one more request
//   is taken into the input stage; then in_ready drops until space frees.
module burn_wire_pulse_sequencer #(
  parameter int PERIOD_MS        = 50,
  parameter int PERIODS_PER_UNIT = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bws_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bws_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [bws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bws_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic               stage_valid;
  bws_pkg::in_item_t  stage_item;
  logic               out_free;
  logic               advance;
  bws_pkg::cfg_t      cfg;
  bws_pkg::out_item_t core_result;

  // Handshake between the two stages
  assign out_free = !out_valid || out_ready;
  assign advance  = stage_valid && out_free;
  assign in_ready = !stage_valid || out_free;

  // Input stage: take a beat whenever the stage is free or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_item;
    end
  end

  // Output stage: hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= core_result;
    end
  end

  bws_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bws_core #(
    .PERIOD_MS        (PERIOD_MS),
    .PERIODS_PER_UNIT (PERIODS_PER_UNIT)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (stage_item),
    .cfg    (cfg),
    .result (core_result)
  );

endmodule
